### sv/wsfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_pkg
// Types, codes and sizes shared by the websocket frame receiver files.
// ----------------------------------------------------------------------------
package wsfr_pkg;

    // width of the stored payload length and payload counter
    localparam int LEN_W = 64;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // results one item can cause, and the widths that follow
    localparam int MAX_RES = 10;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    // header fields
    localparam logic [7:0] HDR_MASK_BIT = 8'h80;
    localparam logic [7:0] HDR_OP_MASK = 8'h0F;
    localparam logic [7:0] HDR_LEN_MASK = 8'h7F;
    localparam logic [6:0] LEN7_MAX = 7'd125;
    localparam logic [6:0] LEN_CODE16 = 7'd126;
    localparam logic [6:0] LEN_CODE64 = 7'd127;
    localparam logic [63:0] LEN16_MAX = 64'h0000_0000_0000_FFFF;
    localparam logic [3:0] EXT_BYTES16 = 4'd2;
    localparam logic [3:0] EXT_BYTES64 = 4'd8;
    localparam logic [3:0] MASK_BYTES = 4'd4;

    // opcodes
    localparam logic [3:0] OP_CONT = 4'd0;
    localparam logic [3:0] OP_BIN = 4'd2;
    localparam logic [3:0] OP_CLOSE = 4'd8;
    localparam logic [3:0] OP_PING = 4'd9;
    localparam logic [3:0] OP_PONG = 4'd10;

    // transmitted header bytes
    localparam logic [7:0] TX_CLOSE = 8'h88;
    localparam logic [7:0] TX_PONG = 8'h8A;
    localparam logic [7:0] TX_ZERO = 8'h00;

    // input kinds
    localparam logic IN_RX_BYTE = 1'b0;
    localparam logic IN_DISCONNECT = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_APP = 2'd0;
    localparam logic [1:0] KIND_TX = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;
    localparam logic [1:0] KIND_CLOSE = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_UNMASKED = 2'd1;
    localparam logic [1:0] ERR_OPCODE = 2'd2;

    // link states
    localparam logic [1:0] LINK_CONNECTED = 2'd0;
    localparam logic [1:0] LINK_CLOSING = 2'd1;
    localparam logic [1:0] LINK_CLOSED = 2'd2;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_MASK,
        PH_DATA
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        last;
        logic [1:0]  err;
        logic [15:0] status;
        logic [1:0]  link;
    } t_res;

endpackage
`default_nettype wire

### sv/wsfr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_in_if
// Input channel: received socket bytes and local disconnect requests.
// ----------------------------------------------------------------------------
interface wsfr_in_if;
    logic       valid;
    logic       ready;
    logic       item_kind;
    logic [7:0] rx_byte;

    modport source (output valid, output item_kind, output rx_byte, input ready);
    modport sink (input valid, input item_kind, input rx_byte, output ready);
endinterface
`default_nettype wire

### sv/wsfr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_out_if
// Result channel: application bytes, transmit bytes and link events.
// ----------------------------------------------------------------------------
interface wsfr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [1:0]  err_code;
    logic [15:0] close_status;
    logic [1:0]  link_state;

    modport source (
        output valid, output out_kind, output out_byte, output out_last,
        output err_code, output close_status, output link_state, input ready
    );
    modport sink (
        input valid, input out_kind, input out_byte, input out_last,
        input err_code, input close_status, input link_state, output ready
    );
endinterface
`default_nettype wire

### sv/websocket_frame_receiver_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_receiver_top
// Frame header parser, payload unmasking, ping echo and close handling.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  i_in    | in  | item_kind, rx_byte
//  o_out   | out | out_kind, out_byte, out_last, err_code, close_status,
//          |     | link_state
//
// an item updates the parser state in the cycle it is accepted and loads its
// results (0 to 10) into a result queue that drains one per cycle while
// o_out.ready is high; items with at most one result then sustain one per
// cycle; an item with n results holds off the next until its last one leaves
// i_in.ready is high while the queue is empty or its last entry leaves
// synchronous reset clears parser state, link state and the queue count
// ----------------------------------------------------------------------------
module websocket_frame_receiver_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    wsfr_in_if.sink      i_in,
    wsfr_out_if.source   o_out
);

    localparam int LW = wsfr_pkg::LEN_W;

    // parser state
    wsfr_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_op, n_op;
    logic [LW-1:0]    r_plen, n_plen;
    logic [3:0]       r_lbc, n_lbc;
    logic [31:0]      r_mask, n_mask;
    logic [LW-1:0]    r_pcnt, n_pcnt;
    logic [15:0]      r_close, n_close;
    logic [1:0]       r_conn, n_conn;
    logic [1:0]       r_err, n_err;
    logic             r_pend, n_pend;

    // result queue
    wsfr_pkg::t_res                   r_q [wsfr_pkg::MAX_RES];
    logic [wsfr_pkg::RES_CNT_W-1:0]   r_cnt;
    wsfr_pkg::t_res                   n_list [wsfr_pkg::MAX_RES];
    logic [wsfr_pkg::RES_CNT_W-1:0]   n_cnt;

    logic in_fire;
    logic out_fire;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;

    assign i_in.ready = (r_cnt == '0) ||
                        (r_cnt == wsfr_pkg::RES_CNT_W'(1) && o_out.ready);

    assign o_out.valid        = (r_cnt != '0);
    assign o_out.out_kind     = r_q[0].kind;
    assign o_out.out_byte     = r_q[0].data;
    assign o_out.out_last     = r_q[0].last;
    assign o_out.err_code     = r_q[0].err;
    assign o_out.close_status = r_q[0].status;
    assign o_out.link_state   = r_q[0].link;

    always_comb begin
        logic [wsfr_pkg::RES_IDX_W-1:0] k;
        logic [1:0]  cs;
        logic [7:0]  b;
        logic [7:0]  u;
        logic [7:0]  mbyte;
        logic [6:0]  len7;
        logic        last;
        logic        fin;
        logic [63:0] len64;
        logic [15:0] status;

        n_phase = r_phase;
        n_op    = r_op;
        n_plen  = r_plen;
        n_lbc   = r_lbc;
        n_mask  = r_mask;
        n_pcnt  = r_pcnt;
        n_close = r_close;
        n_err   = r_err;
        n_pend  = r_pend;
        for (int i = 0; i < wsfr_pkg::MAX_RES; i++) begin
            n_list[i] = '0;
        end
        k      = '0;
        cs     = r_conn;
        b      = i_in.rx_byte;
        fin    = 1'b0;
        len7   = b[6:0] & wsfr_pkg::HDR_LEN_MASK[6:0];
        len64  = 64'(r_plen);
        status = '0;
        last   = 1'b0;
        u      = '0;
        mbyte  = '0;

        if (i_in.item_kind == wsfr_pkg::IN_DISCONNECT) begin
            if (cs == wsfr_pkg::LINK_CONNECTED) begin
                if (r_err == wsfr_pkg::ERR_NONE && r_phase == wsfr_pkg::PH_DATA &&
                    r_op == wsfr_pkg::OP_PING) begin
                    // keep the pong whole, close after its last byte
                    n_pend = 1'b1;
                end else begin
                    cs = wsfr_pkg::LINK_CLOSING;
                    n_list[k] = '{wsfr_pkg::KIND_TX, wsfr_pkg::TX_CLOSE, 1'b0,
                                  wsfr_pkg::ERR_NONE, 16'd0, cs};
                    k = k + 1'b1;
                    n_list[k] = '{wsfr_pkg::KIND_TX, wsfr_pkg::TX_ZERO, 1'b1,
                                  wsfr_pkg::ERR_NONE, 16'd0, cs};
                    k = k + 1'b1;
                end
            end
        end else if (r_err == wsfr_pkg::ERR_NONE && cs != wsfr_pkg::LINK_CLOSED) begin
            unique case (r_phase)
                wsfr_pkg::PH_HDR1: begin
                    if ((b & wsfr_pkg::HDR_MASK_BIT) == 8'd0) begin
                        n_err  = wsfr_pkg::ERR_UNMASKED;
                        n_pend = 1'b0;
                        n_list[k] = '{wsfr_pkg::KIND_ERROR, 8'd0, 1'b0,
                                      wsfr_pkg::ERR_UNMASKED, 16'd0, cs};
                        k = k + 1'b1;
                        n_phase = wsfr_pkg::PH_HDR0;
                    end else begin
                        n_close = '0;
                        n_lbc   = '0;
                        if (len7 <= wsfr_pkg::LEN7_MAX) begin
                            n_plen  = LW'(len7);
                            n_phase = wsfr_pkg::PH_MASK;
                        end else begin
                            n_plen  = '0;
                            n_lbc   = (len7 == wsfr_pkg::LEN_CODE16) ?
                                      wsfr_pkg::EXT_BYTES16 : wsfr_pkg::EXT_BYTES64;
                            n_phase = wsfr_pkg::PH_EXT;
                        end
                    end
                end
                wsfr_pkg::PH_EXT: begin
                    // saturate once another byte would overflow the length
                    if (r_plen > (wsfr_pkg::LEN_MAX >> 8)) begin
                        n_plen = wsfr_pkg::LEN_MAX;
                    end else begin
                        n_plen = {r_plen[LW-9:0], b};
                    end
                    if (r_lbc != 4'd0) begin
                        n_lbc = r_lbc - 4'd1;
                    end
                    if (n_lbc == 4'd0) begin
                        n_phase = wsfr_pkg::PH_MASK;
                    end
                end
                wsfr_pkg::PH_MASK: begin
                    n_mask = {r_mask[23:0], b};
                    n_lbc  = r_lbc + 4'd1;
                    if (n_lbc >= wsfr_pkg::MASK_BYTES) begin
                        n_lbc = '0;
                        if (!(r_op <= wsfr_pkg::OP_BIN ||
                              (r_op >= wsfr_pkg::OP_CLOSE && r_op <= wsfr_pkg::OP_PONG))) begin
                            n_err  = wsfr_pkg::ERR_OPCODE;
                            n_pend = 1'b0;
                            n_list[k] = '{wsfr_pkg::KIND_ERROR, 8'd0, 1'b0,
                                          wsfr_pkg::ERR_OPCODE, 16'd0, cs};
                            k = k + 1'b1;
                        end else begin
                            if (r_op == wsfr_pkg::OP_PING) begin
                                n_list[k] = '{wsfr_pkg::KIND_TX, wsfr_pkg::TX_PONG, 1'b0,
                                              wsfr_pkg::ERR_NONE, 16'd0, cs};
                                k = k + 1'b1;
                                if (len64 <= 64'(wsfr_pkg::LEN7_MAX)) begin
                                    n_list[k] = '{wsfr_pkg::KIND_TX, len64[7:0],
                                                  (len64 == 64'd0), wsfr_pkg::ERR_NONE,
                                                  16'd0, cs};
                                    k = k + 1'b1;
                                end else if (len64 <= wsfr_pkg::LEN16_MAX) begin
                                    n_list[k] = '{wsfr_pkg::KIND_TX, {1'b0, wsfr_pkg::LEN_CODE16},
                                                  1'b0, wsfr_pkg::ERR_NONE, 16'd0, cs};
                                    k = k + 1'b1;
                                    n_list[k] = '{wsfr_pkg::KIND_TX, len64[15:8], 1'b0,
                                                  wsfr_pkg::ERR_NONE, 16'd0, cs};
                                    k = k + 1'b1;
                                    n_list[k] = '{wsfr_pkg::KIND_TX, len64[7:0], 1'b0,
                                                  wsfr_pkg::ERR_NONE, 16'd0, cs};
                                    k = k + 1'b1;
                                end else begin
                                    n_list[k] = '{wsfr_pkg::KIND_TX, {1'b0, wsfr_pkg::LEN_CODE64},
                                                  1'b0, wsfr_pkg::ERR_NONE, 16'd0, cs};
                                    k = k + 1'b1;
                                    for (int i = 7; i >= 0; i--) begin
                                        n_list[k] = '{wsfr_pkg::KIND_TX, len64[8*i +: 8], 1'b0,
                                                      wsfr_pkg::ERR_NONE, 16'd0, cs};
                                        k = k + 1'b1;
                                    end
                                end
                            end
                            n_pcnt = '0;
                            if (r_plen == '0) begin
                                fin = 1'b1;
                            end else begin
                                n_phase = wsfr_pkg::PH_DATA;
                            end
                        end
                    end
                end
                wsfr_pkg::PH_DATA: begin
                    // mask key byte cycles with the low two bits of the count
                    case (r_pcnt[1:0])
                        2'd0:    mbyte = r_mask[31:24];
                        2'd1:    mbyte = r_mask[23:16];
                        2'd2:    mbyte = r_mask[15:8];
                        default: mbyte = r_mask[7:0];
                    endcase
                    u    = b ^ mbyte;
                    last = (LW'(r_pcnt + 1'b1) == r_plen);
                    if (r_op <= wsfr_pkg::OP_BIN) begin
                        n_list[k] = '{wsfr_pkg::KIND_APP, u, last, wsfr_pkg::ERR_NONE,
                                      16'd0, cs};
                        k = k + 1'b1;
                    end else if (r_op == wsfr_pkg::OP_PING) begin
                        n_list[k] = '{wsfr_pkg::KIND_TX, u, last, wsfr_pkg::ERR_NONE,
                                      16'd0, cs};
                        k = k + 1'b1;
                    end else if (r_op == wsfr_pkg::OP_CLOSE) begin
                        if (r_pcnt == '0) begin
                            n_close = {u, 8'd0};
                        end else if (r_pcnt == LW'(1)) begin
                            n_close = r_close | {8'd0, u};
                        end
                    end
                    n_pcnt = LW'(r_pcnt + 1'b1);
                    if (last) begin
                        fin = 1'b1;
                    end
                end
                default: begin
                    n_op    = b[3:0] & wsfr_pkg::HDR_OP_MASK[3:0];
                    n_phase = wsfr_pkg::PH_HDR1;
                end
            endcase

            if (fin) begin
                if (r_op == wsfr_pkg::OP_CLOSE) begin
                    status = (n_plen >= LW'(2)) ? n_close : 16'd0;
                    if (cs == wsfr_pkg::LINK_CLOSING) begin
                        cs = wsfr_pkg::LINK_CLOSED;
                        n_list[k] = '{wsfr_pkg::KIND_CLOSE, 8'd0, 1'b0,
                                      wsfr_pkg::ERR_NONE, status, cs};
                        k = k + 1'b1;
                    end else begin
                        cs = wsfr_pkg::LINK_CLOSING;
                        n_list[k] = '{wsfr_pkg::KIND_CLOSE, 8'd0, 1'b0,
                                      wsfr_pkg::ERR_NONE, status, cs};
                        k = k + 1'b1;
                        n_list[k] = '{wsfr_pkg::KIND_TX, wsfr_pkg::TX_CLOSE, 1'b0,
                                      wsfr_pkg::ERR_NONE, 16'd0, cs};
                        k = k + 1'b1;
                        n_list[k] = '{wsfr_pkg::KIND_TX, wsfr_pkg::TX_ZERO, 1'b1,
                                      wsfr_pkg::ERR_NONE, 16'd0, cs};
                        k = k + 1'b1;
                    end
                end
                if (n_pend) begin
                    n_pend = 1'b0;
                    if (cs == wsfr_pkg::LINK_CONNECTED) begin
                        cs = wsfr_pkg::LINK_CLOSING;
                        n_list[k] = '{wsfr_pkg::KIND_TX, wsfr_pkg::TX_CLOSE, 1'b0,
                                      wsfr_pkg::ERR_NONE, 16'd0, cs};
                        k = k + 1'b1;
                        n_list[k] = '{wsfr_pkg::KIND_TX, wsfr_pkg::TX_ZERO, 1'b1,
                                      wsfr_pkg::ERR_NONE, 16'd0, cs};
                        k = k + 1'b1;
                    end
                end
                n_phase = wsfr_pkg::PH_HDR0;
            end
        end

        n_conn = cs;
        n_cnt  = wsfr_pkg::RES_CNT_W'(k);
    end

    // parser and link state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= wsfr_pkg::PH_HDR0;
            r_op    <= '0;
            r_plen  <= '0;
            r_lbc   <= '0;
            r_mask  <= '0;
            r_pcnt  <= '0;
            r_close <= '0;
            r_conn  <= wsfr_pkg::LINK_CONNECTED;
            r_err   <= wsfr_pkg::ERR_NONE;
            r_pend  <= 1'b0;
        end else if (in_fire) begin
            r_phase <= n_phase;
            r_op    <= n_op;
            r_plen  <= n_plen;
            r_lbc   <= n_lbc;
            r_mask  <= n_mask;
            r_pcnt  <= n_pcnt;
            r_close <= n_close;
            r_conn  <= n_conn;
            r_err   <= n_err;
            r_pend  <= n_pend;
        end
    end

    // result queue count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_fire) begin
            r_cnt <= n_cnt;
        end else if (out_fire) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // result queue payload, head at entry 0
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int i = 0; i < wsfr_pkg::MAX_RES; i++) begin
                r_q[i] <= n_list[i];
            end
        end else if (out_fire) begin
            for (int i = 0; i < wsfr_pkg::MAX_RES - 1; i++) begin
                r_q[i] <= r_q[i+1];
            end
        end
    end

`ifndef SYNTHESIS
    a_closed_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_conn == wsfr_pkg::LINK_CLOSED |=> r_conn == wsfr_pkg::LINK_CLOSED)
        else $error("link left the disconnected state");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != wsfr_pkg::ERR_NONE |=> r_err == $past(r_err))
        else $error("sticky error changed");

    a_pend_in_ping: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_phase == wsfr_pkg::PH_DATA && r_op == wsfr_pkg::OP_PING &&
                    r_err == wsfr_pkg::ERR_NONE))
        else $error("held disconnect outside a ping payload");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= wsfr_pkg::RES_CNT_W'(wsfr_pkg::MAX_RES))
        else $error("result queue overfilled");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> (r_cnt == '0 || (r_cnt == wsfr_pkg::RES_CNT_W'(1) && out_fire)))
        else $error("item accepted over undelivered results");
`endif

endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket frame receiver testbench
// Sends masked frames of every kind through the input channel and checks
// every result against a cycle-free model of the deframer. It ends on a
// sticky error or on a closed link, chosen at random.
// ----------------------------------------------------------------------------
module testbench;
    import wsfr_pkg::*;

    localparam logic [3:0] OP_TEXT = 4'd1;

    typedef enum int {FORM_SHORT, FORM_16, FORM_64} t_len_form;
    typedef enum int {END_CLOSED, END_UNMASKED, END_OPCODE} t_ending;
    typedef enum int {LEAD_PING_DISC, LEAD_CLOSE, LEAD_NONE} t_lead;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       hold;
    } t_rx_item;

    logic i_clk;
    logic i_rst_n;

    wsfr_in_if  in_if ();
    wsfr_out_if out_if ();

    websocket_frame_receiver_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    t_rx_item pending_items[$];
    t_res     due_results[$];
    t_rx_item cur;
    t_res     want;
    bit       hold_next = 1'b0;
    bit       in_acc = 1'b0;
    int       in_count = 0;
    int       res_count = 0;
    int       fail_count = 0;

    // deframer model state
    t_phase           ph = PH_HDR0;
    logic [3:0]       f_op = '0;
    logic [LEN_W-1:0] f_len = '0;
    logic [LEN_W-1:0] f_cnt = '0;
    logic [3:0]       len_bytes = '0;
    logic [31:0]      mkey = '0;
    logic [15:0]      ccode = '0;
    logic [1:0]       link_st = LINK_CONNECTED;
    logic [1:0]       err_flag = ERR_NONE;
    bit               close_hold = 1'b0;

    task automatic push_result(input logic [1:0] kind, input logic [7:0] data,
                               input logic last, input logic [1:0] err,
                               input logic [15:0] status);
        t_res r;
        r.kind = kind;
        r.data = data;
        r.last = last;
        r.err = err;
        r.status = status;
        r.link = link_st;
        due_results.push_back(r);
    endtask

    task automatic push_close_tx();
        push_result(KIND_TX, TX_CLOSE, 1'b0, ERR_NONE, 16'd0);
        push_result(KIND_TX, TX_ZERO, 1'b1, ERR_NONE, 16'd0);
    endtask

    task automatic end_frame();
        logic [15:0] st;
        if (f_op == OP_CLOSE) begin
            st = (f_len >= 2) ? ccode : 16'd0;
            if (link_st == LINK_CLOSING) begin
                link_st = LINK_CLOSED;
                push_result(KIND_CLOSE, 8'd0, 1'b0, ERR_NONE, st);
            end else begin
                link_st = LINK_CLOSING;
                push_result(KIND_CLOSE, 8'd0, 1'b0, ERR_NONE, st);
                push_close_tx();
            end
        end
        // a disconnect held back during a pong goes out now
        if (close_hold) begin
            close_hold = 1'b0;
            if (link_st == LINK_CONNECTED) begin
                link_st = LINK_CLOSING;
                push_close_tx();
            end
        end
        ph = PH_HDR0;
    endtask

    task automatic flag_error(input logic [1:0] code);
        err_flag = code;
        close_hold = 1'b0;
        push_result(KIND_ERROR, 8'd0, 1'b0, code, 16'd0);
    endtask

    task automatic header_complete();
        if (!(f_op <= OP_BIN || (f_op >= OP_CLOSE && f_op <= OP_PONG))) begin
            flag_error(ERR_OPCODE);
        end else begin
            if (f_op == OP_PING) begin
                push_result(KIND_TX, TX_PONG, 1'b0, ERR_NONE, 16'd0);
                if (f_len <= LEN7_MAX) begin
                    push_result(KIND_TX, f_len[7:0], f_len == 0, ERR_NONE, 16'd0);
                end else if (f_len <= LEN16_MAX) begin
                    push_result(KIND_TX, {1'b0, LEN_CODE16}, 1'b0, ERR_NONE, 16'd0);
                    push_result(KIND_TX, f_len[15:8], 1'b0, ERR_NONE, 16'd0);
                    push_result(KIND_TX, f_len[7:0], 1'b0, ERR_NONE, 16'd0);
                end else begin
                    push_result(KIND_TX, {1'b0, LEN_CODE64}, 1'b0, ERR_NONE, 16'd0);
                    for (int i = 7; i >= 0; i--)
                        push_result(KIND_TX, f_len[8*i +: 8], 1'b0, ERR_NONE, 16'd0);
                end
            end
            f_cnt = '0;
            if (f_len == 0)
                end_frame();
            else
                ph = PH_DATA;
        end
    endtask

    task automatic rx_step(input logic [7:0] b);
        logic [7:0] u;
        logic       fin_byte;
        case (ph)
            PH_HDR1: begin
                if ((b & HDR_MASK_BIT) == 0) begin
                    flag_error(ERR_UNMASKED);
                    ph = PH_HDR0;
                end else begin
                    ccode = '0;
                    len_bytes = '0;
                    if ((b & HDR_LEN_MASK) <= LEN7_MAX) begin
                        f_len = b & HDR_LEN_MASK;
                        ph = PH_MASK;
                    end else begin
                        f_len = '0;
                        len_bytes = (b[6:0] == LEN_CODE16) ? EXT_BYTES16 : EXT_BYTES64;
                        ph = PH_EXT;
                    end
                end
            end
            PH_EXT: begin
                // saturate rather than wrap
                if (f_len > (LEN_MAX >> 8))
                    f_len = LEN_MAX;
                else
                    f_len = (f_len << 8) | b;
                if (len_bytes > 0)
                    len_bytes--;
                if (len_bytes == 0)
                    ph = PH_MASK;
            end
            PH_MASK: begin
                mkey = {mkey[23:0], b};
                len_bytes++;
                if (len_bytes >= MASK_BYTES) begin
                    len_bytes = '0;
                    header_complete();
                end
            end
            PH_DATA: begin
                u = b ^ mkey[8*(3 - f_cnt[1:0]) +: 8];
                fin_byte = (f_cnt + 1 == f_len);
                if (f_op <= OP_BIN) begin
                    push_result(KIND_APP, u, fin_byte, ERR_NONE, 16'd0);
                end else if (f_op == OP_PING) begin
                    push_result(KIND_TX, u, fin_byte, ERR_NONE, 16'd0);
                end else if (f_op == OP_CLOSE) begin
                    if (f_cnt == 0)
                        ccode = {u, 8'h00};
                    else if (f_cnt == 1)
                        ccode[7:0] = u;
                end
                f_cnt++;
                if (fin_byte)
                    end_frame();
            end
            default: begin
                f_op = b & HDR_OP_MASK;
                ph = PH_HDR1;
            end
        endcase
    endtask

    task automatic deframe_item(input logic kind, input logic [7:0] b);
        if (kind == IN_DISCONNECT) begin
            if (link_st == LINK_CONNECTED) begin
                if (err_flag == ERR_NONE && ph == PH_DATA && f_op == OP_PING) begin
                    close_hold = 1'b1;
                end else begin
                    link_st = LINK_CLOSING;
                    push_close_tx();
                end
            end
        end else if (err_flag == ERR_NONE && link_st != LINK_CLOSED) begin
            rx_step(b);
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_item(input logic kind, input logic [7:0] data);
        t_rx_item it;
        it.kind = kind;
        it.data = data;
        it.hold = hold_next;
        hold_next = 1'b0;
        pending_items.push_back(it);
    endtask

    task automatic add_frame(input logic [3:0] op, input logic fin,
                             input logic [63:0] len, input t_len_form form,
                             input logic [31:0] key, input int disc_at);
        logic [7:0]      h0;
        longint unsigned k;
        h0 = 8'($urandom);
        h0[3:0] = op;
        h0[7] = fin;
        add_item(IN_RX_BYTE, h0);
        case (form)
            FORM_SHORT: begin
                add_item(IN_RX_BYTE, {1'b1, len[6:0]});
            end
            FORM_16: begin
                add_item(IN_RX_BYTE, {1'b1, LEN_CODE16});
                add_item(IN_RX_BYTE, len[15:8]);
                add_item(IN_RX_BYTE, len[7:0]);
            end
            default: begin
                add_item(IN_RX_BYTE, {1'b1, LEN_CODE64});
                for (int i = 7; i >= 0; i--)
                    add_item(IN_RX_BYTE, len[8*i +: 8]);
            end
        endcase
        for (int i = 3; i >= 0; i--)
            add_item(IN_RX_BYTE, key[8*i +: 8]);
        for (k = 0; k < len; k++) begin
            if (disc_at >= 0 && k == longint'(disc_at))
                add_item(IN_DISCONNECT, 8'($urandom));
            add_item(IN_RX_BYTE, 8'($urandom));
        end
    endtask

    // data, ping and pong frames with mostly short payloads
    task automatic add_random_frame();
        logic [3:0]  op;
        logic [63:0] len;
        t_len_form   form;
        int unsigned r;
        r = $urandom_range(9);
        if (r < 6 || r == 9)
            op = 4'($urandom_range(OP_BIN, OP_CONT));
        else if (r < 8)
            op = OP_PING;
        else
            op = OP_PONG;
        r = $urandom_range(99);
        if (r < 78) begin
            form = FORM_SHORT;
            len = $urandom_range(6);
        end else if (r < 84) begin
            form = FORM_SHORT;
            len = $urandom_range(24, 7);
        end else if (r < 92) begin
            form = FORM_16;
            len = $urandom_range(24);
        end else begin
            form = FORM_64;
            len = $urandom_range(8);
        end
        add_frame(op, 1'($urandom_range(1)), len, form, $urandom, -1);
    endtask

    function automatic bit take_break();
        return !(in_count >= 40 && in_count < 75) && ($urandom_range(99) < 14);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp_val);
        $display("mismatch at result %0d: %s got %0h, wanted %0h",
                 res_count, what, got, exp_val);
        fail_count++;
    endtask

    task automatic cmp_field(input string what, input logic [15:0] got,
                             input logic [15:0] exp_val);
        if (got !== exp_val)
            report_mismatch(what, got, exp_val);
    endtask

    // ------------------------------------------------------------------------
    // driver: inputs change on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_acc) begin
            in_acc = 1'b0;
            if (pending_items.size() != 0
                    && !(pending_items[0].hold && due_results.size() != 0)
                    && !take_break()) begin
                cur = pending_items.pop_front();
                in_if.valid <= 1'b1;
                in_if.item_kind <= cur.kind;
                in_if.rx_byte <= cur.data;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= !take_break();
    end

    // ------------------------------------------------------------------------
    // monitor: accepted items feed the model, results are checked in order
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                deframe_item(in_if.item_kind, in_if.rx_byte);
                in_acc = 1'b1;
                in_count++;
            end
            if (out_if.valid && out_if.ready) begin
                res_count++;
                if (due_results.size() == 0) begin
                    report_mismatch("result with none due", {14'd0, out_if.out_kind}, 16'd0);
                end else begin
                    want = due_results.pop_front();
                    cmp_field("out_kind", out_if.out_kind, want.kind);
                    cmp_field("out_byte", out_if.out_byte, want.data);
                    cmp_field("out_last", out_if.out_last, want.last);
                    cmp_field("err_code", out_if.err_code, want.err);
                    cmp_field("close_status", out_if.close_status, want.status);
                    cmp_field("link_state", out_if.link_state, want.link);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_ending     ending;
        t_lead       lead;
        int          base;
        int unsigned n;
        int unsigned k;
        logic [3:0]  op;

        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.item_kind = IN_RX_BYTE;
        in_if.rx_byte = 8'd0;
        out_if.ready = 1'b0;

        ending = t_ending'($urandom_range(2));
        if (ending == END_CLOSED)
            lead = t_lead'($urandom_range(1));
        else
            lead = t_lead'($urandom_range(2));

        // short directed frames: mask extremes, continuation with fin, empty ping,
        // silent pong
        add_frame(OP_TEXT, 1'b1, 2, FORM_SHORT, 32'hFFFF_FFFF, -1);
        add_frame(OP_CONT, 1'b1, 1, FORM_SHORT, 32'h0000_0000, -1);
        add_frame(OP_PING, 1'b1, 0, FORM_SHORT, $urandom, -1);
        add_frame(OP_PONG, 1'b1, 1, FORM_SHORT, $urandom, -1);

        base = pending_items.size();
        while (pending_items.size() < base + 30)
            add_random_frame();

        // hold off until every result is in, then a ping with a 64-bit length field
        hold_next = 1'b1;
        add_frame(OP_PING, 1'b1, $urandom_range(3), FORM_64, $urandom, -1);

        case (lead)
            LEAD_PING_DISC: begin
                n = $urandom_range(6, 3);
                add_frame(OP_PING, 1'b1, n, FORM_SHORT, $urandom, $urandom_range(n - 1));
            end
            LEAD_CLOSE: begin
                add_frame(OP_CLOSE, 1'b1, $urandom_range(4), FORM_SHORT, $urandom, -1);
            end
            default: ;
        endcase

        // traffic, while closing after a lead frame; a local disconnect here is ignored
        base = pending_items.size();
        if (lead != LEAD_NONE)
            add_item(IN_DISCONNECT, 8'($urandom));
        while (pending_items.size() < base + 10)
            add_random_frame();

        case (ending)
            END_CLOSED: begin
                add_frame(OP_CLOSE, 1'b1, $urandom_range(4), FORM_SHORT, $urandom, -1);
            end
            END_UNMASKED: begin
                add_item(IN_RX_BYTE, 8'($urandom));
                add_item(IN_RX_BYTE, 8'($urandom) & HDR_LEN_MASK);
            end
            default: begin
                if ($urandom_range(1))
                    op = 4'($urandom_range(OP_CLOSE - 1, OP_BIN + 1));
                else
                    op = 4'($urandom_range(4'hF, OP_PONG + 1));
                add_frame(op, 1'($urandom_range(1)), $urandom_range(3), FORM_SHORT,
                          $urandom, -1);
            end
        endcase

        // noise after the link is dead or the error is latched
        k = $urandom_range(11);
        for (int i = 0; i < 12; i++) begin
            if (i == k)
                add_item(IN_DISCONNECT, 8'($urandom));
            add_item(IN_RX_BYTE, 8'($urandom));
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_if.valid)
            @(posedge i_clk);
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
sv/wsfr_pkg.sv
sv/wsfr_in_if.sv
sv/wsfr_out_if.sv
sv/websocket_frame_receiver_top.sv
dv/testbench.sv
